[src/cts_pkg.sv]
`default_nettype none

package cts_pkg;

  localparam int unsigned XW     = 20;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned STAT_W = 2;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [THR_W-1:0] THR_RESET = 16'd66;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SAT   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_LIMIT = 2'd2;

  typedef struct packed {
    logic                 op;
    logic signed [XW-1:0] x_radians;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  cos_value;
    logic [CNT_W-1:0]    terms_used;
    logic [STAT_W-1:0]   status;
  } out_t;

  typedef logic [2:0] pc_t;

  typedef enum logic [1:0] {
    MS_NONE,
    MS_SQ,
    MS_TERM,
    MS_DIV
  } mul_src_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_TAKE,
    C_LOOP,
    C_EMIT
  } cond_e;

  typedef struct packed {
    logic     take;
    mul_src_e mul_src;
    logic     ld_init;
    logic     ld_q;
    logic     ld_term;
    cond_e    cond;
    pc_t      target;
  } uword_t;

  localparam pc_t PC_IDLE = 3'd0;
  localparam pc_t PC_SQ   = 3'd1;
  localparam pc_t PC_INIT = 3'd2;
  localparam pc_t PC_MUL  = 3'd3;
  localparam pc_t PC_RND  = 3'd4;
  localparam pc_t PC_DIV  = 3'd5;
  localparam pc_t PC_UPD  = 3'd6;
  localparam pc_t PC_EMIT = 3'd7;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{take: 1'b0, mul_src: MS_NONE, ld_init: 1'b0, ld_q: 1'b0, ld_term: 1'b0,
          cond: C_NEXT, target: PC_IDLE};
    unique case (pc)
      PC_IDLE: begin
        w.take = 1'b1;
        w.cond = C_TAKE;
      end
      PC_SQ:   w.mul_src = MS_SQ;
      PC_INIT: w.ld_init = 1'b1;
      PC_MUL:  w.mul_src = MS_TERM;
      PC_RND:  w.ld_q = 1'b1;
      PC_DIV:  w.mul_src = MS_DIV;
      PC_UPD: begin
        w.ld_term = 1'b1;
        w.cond    = C_LOOP;
        w.target  = PC_MUL;
      end
      PC_EMIT: begin
        w.cond   = C_EMIT;
        w.target = PC_IDLE;
      end
      default: w.cond = C_NEXT;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/cosine_taylor_series.sv]
`default_nettype none

// Each result takes n terms (FIXED_TERMS in op 0, 1 to MAX_TERMS in op 1). An item is
// taken only in the idle state, so the next item waits until the last has passed the one
// shared multiplier, used twice per term, plus a rounding and an update step per term.
// A result waits in the output register while the next item is taken.
// Reset: sequencer idle, output empty, stop_threshold back to 66.
module cosine_taylor_series #(
  parameter int unsigned MAX_TERMS   = 16,
  parameter int unsigned FIXED_TERMS = 5
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cts_pkg::THR_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire cts_pkg::in_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output cts_pkg::out_t                   out_data_o
);
  import cts_pkg::*;

  localparam int unsigned KW  = $clog2(MAX_TERMS);
  localparam int unsigned TAB = 2 ** KW;

  logic [32:0] recip_m  [TAB];
  logic [5:0]  recip_sh [TAB];
  logic [11:0] coef     [TAB];

  for (genvar g = 0; g < TAB; g++) begin : g_tab
    localparam int unsigned C   = (2 * (g + 1) - 1) * (2 * (g + 1));
    localparam int unsigned L   = $clog2(C);
    localparam logic [63:0] NUM = 64'd1 << (32 + L);
    localparam logic [63:0] M   = (NUM + 64'(C) - 64'd1) / 64'(C);
    assign recip_m[g]  = M[32:0];
    assign recip_sh[g] = 6'(32 + L);
    assign coef[g]     = 12'(C);
  end

  pc_t              pc_q, pc_d;
  uword_t           uw;
  logic [THR_W-1:0] thr_q;
  logic             out_valid_q;
  out_t             out_q;

  logic                     op_q;
  logic [XW-1:0]            ax_q, ax_d, raw_u;
  logic [64:0]              prod_q, prod_d;
  logic [32:0]              mul_a;
  logic [31:0]              mul_b;
  logic [22:0]              x2_q, x2_d;
  logic [39:0]              sq_rnd;
  logic [31:0]              q_q, q_d;
  logic [48:0]              q_rnd;
  logic [25:0]              mag_q, mag_new;
  logic [64:0]              shifted;
  logic signed [31:0]       sum_q, sum_new;
  logic signed [33:0]       sum_ext;
  logic [CNT_W-1:0]         k_q, k_m1;
  logic [KW-1:0]            idx;
  logic                     neg_q, neg_new, sat_q, sat_new, below_q, below_now;
  logic                     limit_hit, stop, clamp_hi, clamp_lo;
  logic                     take_fire, out_free, emit;
  out_t                     result;

  assign uw        = ucode(pc_q);
  assign in_stall_o = ~uw.take;
  assign take_fire = uw.take & in_valid_i;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign emit      = (uw.cond == C_EMIT) & out_free;

  assign k_m1 = k_q - 6'd1;
  assign idx  = k_m1[KW-1:0];

  assign raw_u = in_data_i.x_radians;
  assign ax_d  = raw_u[XW-1] ? (~raw_u + 20'd1) : raw_u;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul_src)
      MS_SQ: begin
        mul_a = 33'(ax_q);
        mul_b = 32'(ax_q);
      end
      MS_TERM: begin
        mul_a = 33'(mag_q);
        mul_b = 32'(x2_q);
      end
      MS_DIV: begin
        mul_a = recip_m[idx];
        mul_b = q_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = {32'd0, mul_a} * {33'd0, mul_b};
  end

  assign sq_rnd = prod_q[39:0] + 40'd32768;
  assign x2_d   = sq_rnd[38:16];

  assign q_rnd = {1'b0, prod_q[47:0]} + {22'd0, coef[idx], 15'd0};
  assign q_d   = q_rnd[47:16];

  assign shifted = prod_q >> recip_sh[idx];
  assign mag_new = shifted[25:0];
  assign neg_new = ~neg_q;

  always_comb begin
    if (neg_new) begin
      sum_ext = {{2{sum_q[31]}}, sum_q} - $signed({8'd0, mag_new});
    end else begin
      sum_ext = {{2{sum_q[31]}}, sum_q} + $signed({8'd0, mag_new});
    end
    clamp_hi = sum_ext > 34'sd2147483647;
    clamp_lo = sum_ext < -34'sd2147483648;
    if (clamp_hi) begin
      sum_new = 32'sh7FFF_FFFF;
    end else if (clamp_lo) begin
      sum_new = 32'sh8000_0000;
    end else begin
      sum_new = sum_ext[31:0];
    end
  end

  assign sat_new   = sat_q | clamp_hi | clamp_lo;
  assign below_now = op_q & (mag_new <= {10'd0, thr_q});
  assign limit_hit = k_q == (op_q ? CNT_W'(MAX_TERMS) : CNT_W'(FIXED_TERMS));
  assign stop      = below_now | limit_hit;

  always_comb begin
    result.cos_value  = sum_q;
    result.terms_used = k_q;
    if (sat_q) begin
      result.status = STATUS_SAT;
    end else if (op_q & ~below_q) begin
      result.status = STATUS_LIMIT;
    end else begin
      result.status = STATUS_OK;
    end
  end

  always_comb begin
    pc_d = pc_q;
    unique case (uw.cond)
      C_NEXT: pc_d = pc_q + 3'd1;
      C_TAKE: pc_d = in_valid_i ? pc_q + 3'd1 : pc_q;
      C_LOOP: pc_d = stop ? pc_q + 3'd1 : uw.target;
      C_EMIT: pc_d = out_free ? uw.target : pc_q;
      default: pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_fire) begin
      op_q <= in_data_i.op;
      ax_q <= ax_d;
    end
    if (uw.mul_src != MS_NONE) begin
      prod_q <= prod_d;
    end
    if (uw.ld_init) begin
      x2_q    <= x2_d;
      mag_q   <= {9'd0, ONE_Q16};
      sum_q   <= {15'd0, ONE_Q16};
      k_q     <= 6'd1;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      below_q <= 1'b0;
    end
    if (uw.ld_q) begin
      q_q <= q_d;
    end
    if (uw.ld_term) begin
      mag_q   <= mag_new;
      sum_q   <= sum_new;
      neg_q   <= neg_new;
      sat_q   <= sat_new;
      below_q <= below_now;
      if (!stop) begin
        k_q <= k_q + 6'd1;
      end
    end
    if (emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[bench/cosine_taylor_series_tb.sv]
`default_nettype none

module cosine_taylor_series_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int unsigned MAX_TERMS   = 16;
  localparam int unsigned FIXED_TERMS = 5;
  localparam int unsigned SETTLE      = 4 + 4 * MAX_TERMS + 8;
  localparam int unsigned WATCHDOG    = 5000;
  localparam int unsigned PHASE_ITEMS = 366;

  localparam logic OP_FIXED  = 1'b0;
  localparam logic OP_THRESH = 1'b1;

  localparam logic signed [XW-1:0] X_MAX = 20'sh7FFFF;
  localparam logic signed [XW-1:0] X_MIN = 20'sh80000;

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  typedef struct packed {
    logic                 op;
    logic signed [XW-1:0] x;
    logic                 typed;
    out_t                 want;
  } row_t;

  localparam int unsigned N_ROWS = 20;

  row_t dir_rows [N_ROWS] = '{
    '{OP_FIXED,  20'sd0,       1'b1, '{32'sd65536, 6'd5, STATUS_OK}},
    '{OP_THRESH, 20'sd0,       1'b1, '{32'sd65536, 6'd1, STATUS_OK}},
    '{OP_THRESH, 20'sd1,       1'b1, '{32'sd65536, 6'd1, STATUS_OK}},
    '{OP_FIXED,  -20'sd1,      1'b1, '{32'sd65536, 6'd5, STATUS_OK}},
    '{OP_FIXED,  X_MAX,        1'b0, '0},
    '{OP_THRESH, X_MAX,        1'b0, '0},
    '{OP_FIXED,  X_MIN,        1'b0, '0},
    '{OP_THRESH, X_MIN,        1'b0, '0},
    '{OP_FIXED,  20'sd65536,   1'b0, '0},
    '{OP_THRESH, -20'sd65536,  1'b0, '0},
    '{OP_FIXED,  20'sd205887,  1'b0, '0},
    '{OP_THRESH, 20'sd205887,  1'b0, '0},
    '{OP_THRESH, -20'sd205887, 1'b0, '0},
    '{OP_THRESH, 20'sd102944,  1'b0, '0},
    '{OP_THRESH, 20'sd411775,  1'b0, '0},
    '{OP_FIXED,  20'sh55555,   1'b0, '0},
    '{OP_THRESH, 20'shAAAAA,   1'b0, '0},
    '{OP_THRESH, 20'sd181,     1'b0, '0},
    '{OP_THRESH, 20'sd182,     1'b0, '0},
    '{OP_FIXED,  20'sd256,     1'b0, '0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [THR_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;

  logic [THR_W-1:0]  stop_thr = THR_RESET;
  bit                calm = 1'b0;
  out_t              cos_due [$];
  out_t              due;
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;

  cosine_taylor_series #(
    .MAX_TERMS  (MAX_TERMS),
    .FIXED_TERMS(FIXED_TERMS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #10 clk = ~clk;

  function automatic out_t cos_series(input logic op, input logic signed [XW-1:0] x,
                                      input logic [THR_W-1:0] thr);
    logic [XW-1:0] ax;
    longint        x2;
    longint        mag;
    longint        d;
    longint        sum;
    bit            neg;
    bit            sat;
    bit            below;
    int            lim;
    int            cnt;
    out_t          r;
    ax    = x[XW-1] ? XW'(~x + 1'b1) : XW'(x);
    x2    = (longint'(ax) * longint'(ax) + 32768) >>> 16;
    mag   = 65536;
    sum   = 65536;
    neg   = 1'b0;
    sat   = 1'b0;
    below = 1'b0;
    cnt   = 0;
    lim   = (op == OP_THRESH) ? MAX_TERMS : FIXED_TERMS;
    for (int k = 1; k <= lim; k++) begin
      d   = longint'((2 * k - 1) * (2 * k)) * 65536;
      mag = (mag * x2 + d / 2) / d;
      neg = !neg;
      sum = neg ? sum - mag : sum + mag;
      if (sum > SUM_HI) begin
        sum = SUM_HI;
        sat = 1'b1;
      end
      if (sum < SUM_LO) begin
        sum = SUM_LO;
        sat = 1'b1;
      end
      cnt++;
      if (op == OP_THRESH && mag <= longint'(thr)) begin
        below = 1'b1;
        break;
      end
    end
    r.cos_value  = sum[31:0];
    r.terms_used = CNT_W'(cnt);
    if (sat)
      r.status = STATUS_SAT;
    else if (op == OP_THRESH && !below)
      r.status = STATUS_LIMIT;
    else
      r.status = STATUS_OK;
    return r;
  endfunction

  task automatic send(input in_t item, input out_t want);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cos_due.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cos_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_thr(input logic [THR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stop_thr  = value;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cos_due.size() == 0) begin
        $error("unexpected result: cos_value %0d terms_used %0d status %0d",
               out_data.cos_value, out_data.terms_used, out_data.status);
        mismatches++;
      end else begin
        due = cos_due.pop_front();
        if (out_data.cos_value !== due.cos_value) begin
          $error("cos_value: expected %0d, got %0d", due.cos_value, out_data.cos_value);
          mismatches++;
        end
        if (out_data.terms_used !== due.terms_used) begin
          $error("terms_used: expected %0d, got %0d", due.terms_used, out_data.terms_used);
          mismatches++;
        end
        if (out_data.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("cosine_taylor_series test failed");
      $finish;
    end
  end

  initial begin
    logic [THR_W-1:0]     thr_plan [5];
    logic signed [XW-1:0] xr;
    in_t                  item;
    out_t                 want;

    thr_plan = '{16'd0, 16'hFFFF, 16'd1, THR_W'($urandom_range(2, 4000)), THR_RESET};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      item.op        = dir_rows[i].op;
      item.x_radians = dir_rows[i].x;
      want = dir_rows[i].typed ? dir_rows[i].want : cos_series(item.op, item.x_radians, stop_thr);
      send(item, want);
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      write_thr(thr_plan[p]);
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(3))
          0, 1: xr = XW'($urandom);
          2: begin
            xr = XW'($urandom_range(0, 131072));
            if ($urandom_range(1)) xr = -xr;
          end
          default: xr = $urandom_range(1) ? X_MAX - XW'($urandom_range(0, 255))
                                            : X_MIN + XW'($urandom_range(0, 255));
        endcase
        item.op        = $urandom_range(1) ? OP_THRESH : OP_FIXED;
        item.x_radians = xr;
        send(item, cos_series(item.op, item.x_radians, stop_thr));
      end
      calm = 1'b0;
    end

    drain();
    if (mismatches == 0)
      $display("cosine_taylor_series test passed");
    else
      $display("cosine_taylor_series test failed");
    $finish;
  end

endmodule

`default_nettype wire
